// File: src/sr2u_pkg.sv
`default_nettype none

package sr2u_pkg;

  localparam int DATA_W       = 32;
  localparam int IDX_W        = 6;
  localparam int SIZE_W       = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_SIZE_DEF = 64;
  // the walk counters and index field are 6 bits wide, so N never exceeds this
  localparam int SIZE_CAP     = 64;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W   = 104;
  localparam int OUT_TDATA_W  = 48;

  localparam logic [DATA_W-1:0] ALPHA_RST = 32'h0001_0000;
  localparam logic [SIZE_W-1:0] SIZE_RST  = 7'd64;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_UPDATE = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_ACCUM = 2'd1,
    CFG_SIZE  = 2'd2
  } cfg_e;

endpackage

`default_nettype wire

// File: src/symmetric_rank2_update_top.sv
// symmetric rank-2 update of the lower triangle, signed q16.16, saturating
// throughput: one beat per cycle while the result stream is not stalled, loads and updates freely mixed
// an update's result beat is registered in turn by the input register, the store read,
// the product, the product sum and then the accumulate and clip register
// a load is written into the stores from stage 2; a forwarding path lets the very next beat use it
// reset empties the pipeline, zeroes the walk and restores the config; stores are not cleared
`default_nettype none

module symmetric_rank2_update_top #(
  parameter int MAX_SIZE = sr2u_pkg::MAX_SIZE_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // config write port
  input  wire logic                             cfg_we_i,
  input  wire logic [sr2u_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sr2u_pkg::DATA_W-1:0]      cfg_wdata_i,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // index[5:0], x_value[37:6], y_value[69:38], a_value[101:70], zero pad
  input  wire logic [sr2u_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  wire logic                             s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // a_out[31:0], row[37:32], col[43:38], saturated[44], zero pad
  output logic      [sr2u_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast
);
  import sr2u_pkg::*;

  // usable depth: the 6-bit walk limits N to 64 regardless of MAX_SIZE
  localparam int DEPTH = (MAX_SIZE < SIZE_CAP) ? MAX_SIZE : SIZE_CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SIZE_W-1:0] DEPTH_S = SIZE_W'(DEPTH);
  localparam logic [SIZE_W-1:0] ONE_S   = SIZE_W'(1);

  // saturate a 50-bit signed value to 32 bits, flag in the top bit
  function automatic logic [DATA_W:0] clip50(input logic [49:0] v);
    logic fits;
    fits = (&v[49:31]) | (~|v[49:31]);
    if (fits) begin
      clip50 = {1'b0, v[31:0]};
    end else if (v[49]) begin
      clip50 = {1'b1, 32'h8000_0000};
    end else begin
      clip50 = {1'b1, 32'h7FFF_FFFF};
    end
  endfunction

  // ---------------------------------------------------------------- config
  logic [DATA_W-1:0] alpha_q;
  logic              accum_q;
  logic [SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      accum_q <= 1'b1;
      size_q  <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA: alpha_q <= cfg_wdata_i;
        CFG_ACCUM: accum_q <= cfg_wdata_i[0];
        CFG_SIZE:  size_q  <= cfg_wdata_i[SIZE_W-1:0];
        default:   ;
      endcase
    end
  end

  // effective N: zero acts as one, clipped to the store depth
  logic [SIZE_W-1:0] n_eff;
  always_comb begin
    if (size_q == '0) begin
      n_eff = ONE_S;
    end else if (size_q > DEPTH_S) begin
      n_eff = DEPTH_S;
    end else begin
      n_eff = size_q;
    end
  end

  // ----------------------------------------------------------- input fields
  logic [IDX_W-1:0]  in_index;
  logic [DATA_W-1:0] in_x;
  logic [DATA_W-1:0] in_y;
  logic [DATA_W-1:0] in_a;
  func_e             in_func;

  assign in_index = s_axis_tdata[5:0];
  assign in_x     = s_axis_tdata[37:6];
  assign in_y     = s_axis_tdata[69:38];
  assign in_a     = s_axis_tdata[101:70];
  assign in_func  = func_e'(s_axis_tuser);

  // -------------------------------------------------------- pipeline control
  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  func_e func1_q, func2_q;
  logic rdy1, rdy2, rdy3, rdy4, out_rdy;
  logic accept;

  // each stage moves when it is empty or its successor moves;
  // a load leaves stage 2 by writing the stores and never reaches stage 3
  always_comb begin
    out_rdy = !ov_q || m_axis_tready;
    rdy4    = !v4_q || out_rdy;
    rdy3    = !v3_q || rdy4;
    rdy2    = !v2_q || (func2_q == FUNC_LOAD) || rdy3;
    rdy1    = !v1_q || rdy2;
  end

  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  // ------------------------------------------------------------ walk position
  logic [IDX_W-1:0]  row_q, col_q, row_d, col_d;
  logic [IDX_W-1:0]  walk_r, walk_c;
  logic              walk_last;
  logic [SIZE_W-1:0] r_plus1;
  logic              restart;

  always_comb begin
    // a stale position (N shrunk) restarts the walk at the origin
    restart   = ({1'b0, row_q} >= n_eff) || (col_q > row_q);
    walk_r    = restart ? '0 : row_q;
    walk_c    = restart ? '0 : col_q;
    walk_last = ({1'b0, walk_r} == (n_eff - ONE_S)) && (walk_c == walk_r);
    r_plus1   = {1'b0, walk_r} + ONE_S;
    if (walk_c < walk_r) begin
      col_d = walk_c + IDX_W'(1);
      row_d = walk_r;
    end else begin
      col_d = '0;
      row_d = (r_plus1 >= n_eff) ? '0 : r_plus1[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept && (in_func == FUNC_UPDATE)) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // -------------------------------------------------------- valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      ov_q    <= 1'b0;
      func1_q <= FUNC_LOAD;
      func2_q <= FUNC_LOAD;
    end else begin
      if (rdy1) begin
        v1_q    <= s_axis_tvalid;
        func1_q <= in_func;
      end
      if (rdy2) begin
        v2_q    <= v1_q;
        func2_q <= func1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q && (func2_q == FUNC_UPDATE);
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (out_rdy) begin
        ov_q <= v4_q;
      end
    end
  end

  // -------------------------------------------------- stage 1: input register
  logic [IDX_W-1:0]  idx1_q;
  logic [DATA_W-1:0] x1_q, y1_q, a1_q;
  logic [IDX_W-1:0]  r1_q, c1_q;
  logic              last1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      idx1_q  <= in_index;
      x1_q    <= in_x;
      y1_q    <= in_y;
      a1_q    <= in_a;
      r1_q    <= walk_r;
      c1_q    <= walk_c;
      last1_q <= walk_last;
    end
  end

  // ---------------------------- stage 2: alpha*x product, or store read data
  logic signed [DATA_W-1:0]   alpha_s, x1_s;
  logic signed [2*DATA_W-1:0] prodx_d;
  logic signed [2*DATA_W-1:0] prodx2_q;
  logic [IDX_W-1:0]           idx2_q;
  logic [DATA_W-1:0]          y2_q, a2_q;
  logic [IDX_W-1:0]           r2_q, c2_q;
  logic                       last2_q;

  assign alpha_s = alpha_q;
  assign x1_s    = x1_q;
  assign prodx_d = alpha_s * x1_s;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      prodx2_q <= prodx_d;
      idx2_q   <= idx1_q;
      y2_q     <= y1_q;
      a2_q     <= a1_q;
      r2_q     <= r1_q;
      c2_q     <= c1_q;
      last2_q  <= last1_q;
    end
  end

  // scaled x: floor(alpha*x / 2^16), saturated without a flag
  logic [DATA_W:0]   sx_clip;
  logic [DATA_W-1:0] sx_wdata;
  logic              st_we;
  logic              st_re;

  assign sx_clip  = clip50({{2{prodx2_q[63]}}, prodx2_q[63:16]});
  assign sx_wdata = sx_clip[DATA_W-1:0];
  // loads beyond the store depth are dropped
  assign st_we    = v2_q && (func2_q == FUNC_LOAD) && ({1'b0, idx2_q} < DEPTH_S);
  assign st_re    = v1_q && (func1_q == FUNC_UPDATE) && rdy2;

  logic [DATA_W-1:0] sx_r, sx_c, yv_r, yv_c;

  sr2u_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_sx_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (idx2_q[AW-1:0]),
    .wdata_i   (sx_wdata),
    .re_i      (st_re),
    .raddr_a_i (r1_q[AW-1:0]),
    .raddr_b_i (c1_q[AW-1:0]),
    .rdata_a_o (sx_r),
    .rdata_b_o (sx_c)
  );

  sr2u_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_y_store (
    .clk_i     (clk_i),
    .we_i      (st_we),
    .waddr_i   (idx2_q[AW-1:0]),
    .wdata_i   (y2_q),
    .re_i      (st_re),
    .raddr_a_i (r1_q[AW-1:0]),
    .raddr_b_i (c1_q[AW-1:0]),
    .rdata_a_o (yv_r),
    .rdata_b_o (yv_c)
  );

  // ----------------------------------------------- stage 3: the two products
  logic signed [DATA_W-1:0]   sx_r_s, sx_c_s, yv_r_s, yv_c_s;
  logic signed [2*DATA_W-1:0] p1_d, p2_d;
  logic signed [2*DATA_W-1:0] p1_q, p2_q;
  logic [DATA_W-1:0]          a3_q;
  logic [IDX_W-1:0]           r3_q, c3_q;
  logic                       last3_q;

  assign sx_r_s = sx_r;
  assign sx_c_s = sx_c;
  assign yv_r_s = yv_r;
  assign yv_c_s = yv_c;
  assign p1_d   = sx_r_s * yv_c_s;
  assign p2_d   = yv_r_s * sx_c_s;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      a3_q    <= a2_q;
      r3_q    <= r2_q;
      c3_q    <= c2_q;
      last3_q <= last2_q;
    end
  end

  // -------------------------------- stage 4: floor((p1 + p2) / 2^16), 49 bits
  logic [2*DATA_W:0] psum;
  logic [48:0]       sum4_q;
  logic [DATA_W-1:0] a4_q;
  logic [IDX_W-1:0]  r4_q, c4_q;
  logic              last4_q;

  assign psum = {p1_q[63], p1_q} + {p2_q[63], p2_q};

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      sum4_q  <= psum[64:16];
      a4_q    <= a3_q;
      r4_q    <= r3_q;
      c4_q    <= c3_q;
      last4_q <= last3_q;
    end
  end

  // -------------------------------------- output: optional add of A, then clip
  logic [49:0]       acc_sum;
  logic [DATA_W:0]   res_clip;
  logic [DATA_W-1:0] aout_q;
  logic [IDX_W-1:0]  row_out_q, col_out_q;
  logic              last_out_q, sat_out_q;

  assign acc_sum  = {sum4_q[48], sum4_q}
                  + (accum_q ? {{18{a4_q[31]}}, a4_q} : 50'd0);
  assign res_clip = clip50(acc_sum);

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      aout_q     <= res_clip[DATA_W-1:0];
      sat_out_q  <= res_clip[DATA_W];
      row_out_q  <= r4_q;
      col_out_q  <= c4_q;
      last_out_q <= last4_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {3'b000, sat_out_q, col_out_q, row_out_q, aout_q};
  assign m_axis_tlast  = last_out_q;

  // --------------------------------------------------------------- assertions
  // the walk never points above the diagonal
  a_walk_lower : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= row_q)
    else $error("walk column above row");

  // the last entry of the triangle sits on the diagonal
  a_last_diag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (row_out_q == col_out_q))
    else $error("last beat off the diagonal");

  // input back-pressure only when every stage is full and the output is stalled
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && ov_q && !m_axis_tready))
    else $error("input stalled with a free stage");

  // a load in stage 2 never blocks the stage behind it
  a_load_flows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && (func2_q == FUNC_LOAD)) |-> rdy1)
    else $error("load held in stage 2");

endmodule

`default_nettype wire

// File: src/sr2u_store.sv
`default_nettype none

module sr2u_store #(
  parameter int DEPTH = sr2u_pkg::MAX_SIZE_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [sr2u_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_a_i,
  input  wire logic [AW-1:0]               raddr_b_i,
  output logic      [sr2u_pkg::DATA_W-1:0] rdata_a_o,
  output logic      [sr2u_pkg::DATA_W-1:0] rdata_b_o
);
  import sr2u_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_a_q;
  logic [DATA_W-1:0] rdata_b_q;

  // write-first: a read at the address being written sees the new word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= (we_i && (waddr_i == raddr_a_i)) ? wdata_i : mem[raddr_a_i];
      rdata_b_q <= (we_i && (waddr_i == raddr_b_i)) ? wdata_i : mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sr2u_pkg::*;

  // pipeline delay allowance for an update beat, used to size the settle wait
  localparam int LATENCY        = 4;
  localparam int SETTLE_CYCLES  = LATENCY + 3;
  // cycles without any beat on either stream before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_PHASES    = 12;

  // one input beat as the block sees it
  typedef struct packed {
    func_e              func;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic signed [31:0] a_value;
  } in_beat_t;

  // one updated matrix entry
  typedef struct packed {
    logic signed [31:0] a_out;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic               last;
    logic               saturated;
  } entry_t;

  // dut ports, all inputs known from time zero
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_ALPHA;
  logic [DATA_W-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = FUNC_LOAD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  // beats waiting for the driver and entries waiting for the dut
  in_beat_t pending_beats[$];
  entry_t   expected_entries[$];
  in_beat_t drv_beat;
  bit       beat_taken     = 1'b0;
  int       beats_queued   = 0;
  int       beats_accepted = 0;
  int       errors         = 0;
  int       stall_cycles   = 0;
  int       src_idle_pct   = 0;
  int       sink_stall_pct = 0;

  // shadow of the config registers
  logic signed [31:0] alpha_q = ALPHA_RST;
  logic               accum_q = 1'b1;
  logic [SIZE_W-1:0]  size_q  = SIZE_RST;

  // shadow of the vector stores and the walk position
  logic signed [31:0] sx_mem [SIZE_CAP];
  logic signed [31:0] y_mem  [SIZE_CAP];
  bit                 loaded [SIZE_CAP];
  logic [IDX_W-1:0]   row_q = '0;
  logic [IDX_W-1:0]   col_q = '0;

  symmetric_rank2_update_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // clip a wide sum to 32 bits, flag set when clipped
  function automatic logic [31:0] clip_q16(input longint v, output logic clipped);
    logic [31:0] r;
    clipped = 1'b1;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
      clipped = 1'b0;
    end
    return r;
  endfunction

  // matrix dimension actually walked: 0 acts as 1, anything above the cap is clipped
  function automatic int walk_size();
    int n;
    n = size_q;
    if (n < 1) n = 1;
    if (n > SIZE_CAP) n = SIZE_CAP;
    return n;
  endfunction

  // advance the shadow by one taken beat; updates queue the entry they produce
  task automatic apply_beat(input in_beat_t b);
    int     n;
    longint p1;
    longint p2;
    longint lo;
    longint sum;
    logic   clipped;
    entry_t e;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    if (b.func == FUNC_LOAD) begin
      // x is stored already scaled by alpha, floored, clipped without a flag
      p1 = longint'(alpha_q) * longint'(b.x_value);
      sx_mem[b.index] = clip_q16(p1 >>> 16, clipped);
      y_mem[b.index]  = b.y_value;
    end else begin
      n = walk_size();
      // a walk left beyond a shrunken size restarts at the origin
      if (row_q >= n || col_q > row_q) begin
        row_q = '0;
        col_q = '0;
      end
      r = row_q;
      c = col_q;
      p1 = longint'(sx_mem[r]) * longint'(y_mem[c]);
      p2 = longint'(y_mem[r]) * longint'(sx_mem[c]);
      // floor of the exact sum without overflowing 64 bits
      lo  = ((p1 & 64'hFFFF) + (p2 & 64'hFFFF)) >> 16;
      sum = (p1 >>> 16) + (p2 >>> 16) + lo;
      if (accum_q) sum = sum + longint'(b.a_value);
      e.a_out     = clip_q16(sum, clipped);
      e.saturated = clipped;
      e.row       = r;
      e.col       = c;
      e.last      = (r == n - 1) && (c == r);
      expected_entries.push_back(e);
      if (c < r) begin
        col_q = c + 1'b1;
      end else begin
        col_q = '0;
        row_q = (r + 1 >= n) ? '0 : r + 1'b1;
      end
    end
  endtask

  // q16.16 operand: full range, small magnitude or an edge value
  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(32'h0008_0000) - 32'h0004_0000;
      1: begin
        case ($urandom_range(5))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          3:       v = 32'hFFFF_FFFF;
          4:       v = 32'h0001_0000;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_load(input logic [IDX_W-1:0] idx, input logic [31:0] x,
                            input logic [31:0] y);
    in_beat_t b;
    b.func    = FUNC_LOAD;
    b.index   = idx;
    b.x_value = x;
    b.y_value = y;
    // a is don't care on a load, keep it toggling
    b.a_value = $urandom;
    loaded[idx] = 1'b1;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_update(input logic [31:0] a);
    in_beat_t b;
    b.func    = FUNC_UPDATE;
    b.index   = IDX_W'($urandom);
    b.x_value = $urandom;
    b.y_value = $urandom;
    b.a_value = a;
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  // register write, only issued with the block idle
  task automatic write_reg(input cfg_e idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ALPHA: alpha_q = val;
      CFG_ACCUM: accum_q = val[0];
      CFG_SIZE:  size_q  = val[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every beat is taken and every entry has come back, then let loads settle
  task automatic drain();
    while (beats_accepted != beats_queued || expected_entries.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // make sure the walk never reads a store entry that was never loaded
  task automatic fill_stores();
    for (int i = 0; i < walk_size(); i++)
      if (!loaded[i]) queue_load(IDX_W'(i), rand_q16(), rand_q16());
  endtask

  // driver: holds a beat until taken, then maybe idles, changes only on falling edges
  always @(negedge clk_i) begin
    logic hold;
    if (rst_ni) begin
      hold = s_axis_tvalid && !beat_taken;
      beat_taken = 1'b0;
      if (!hold) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_beat = pending_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, drv_beat.a_value, drv_beat.y_value,
                            drv_beat.x_value, drv_beat.index};
          s_axis_tuser  <= drv_beat.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: both streams sampled on rising edges, plus the hang watchdog
  always @(posedge clk_i) begin
    entry_t got;
    entry_t want;
    bit     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        apply_beat(drv_beat);
        beat_taken = 1'b1;
        beats_accepted++;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved         = 1'b1;
        got.a_out     = m_axis_tdata[31:0];
        got.row       = m_axis_tdata[37:32];
        got.col       = m_axis_tdata[43:38];
        got.saturated = m_axis_tdata[44];
        got.last      = m_axis_tlast;
        if (expected_entries.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none,", $time,
                   " got a=%h row=%0d col=%0d last=%b sat=%b",
                   got.a_out, got.row, got.col, got.last, got.saturated);
        end else begin
          want = expected_entries.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: result mismatch, expected a=%h row=%0d col=%0d last=%b sat=%b,",
                     $time, want.a_out, want.row, want.col, want.last, want.saturated,
                     " got a=%h row=%0d col=%0d last=%b sat=%b",
                     got.a_out, got.row, got.col, got.last, got.saturated);
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int n_items;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed: 4x4 walk with extreme vectors, saturation both ways, a zero row
    write_reg(CFG_SIZE, 4);
    queue_load(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_load(1, 32'h8000_0000, 32'h8000_0000);
    queue_load(2, 32'h0000_0000, 32'h0000_0000);
    queue_load(3, 32'hFFFF_FFFF, 32'h0001_0000);
    queue_load(63, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_update(32'h7FFF_FFFF);
    queue_update(32'h8000_0000);
    queue_update(32'h0000_0000);
    queue_update(32'hFFFF_FFFF);
    queue_update(32'h0001_0000);
    queue_update(32'h7FFF_FFFF);
    queue_update(32'h8000_0000);
    drain();
    // walk now sits at row 3, shrinking the size forces a restart at the origin
    write_reg(CFG_SIZE, 2);
    queue_update(32'h0000_0001);
    queue_update(32'hFFFF_FFFF);
    queue_update(32'h8000_0000);
    drain();
    // overwrite entry 0 with alpha zero and no accumulate: entry (0,0) comes back zero
    write_reg(CFG_ACCUM, 0);
    write_reg(CFG_ALPHA, 0);
    queue_load(0, 32'h0001_2345, 32'hFFFE_6789);
    queue_update(32'h7FFF_FFFF);
    queue_update(32'h8000_0000);
    queue_update(32'h1234_5678);
    drain();
    // size zero walks a single entry, each one marked last
    write_reg(CFG_SIZE, 0);
    write_reg(CFG_ALPHA, 32'hFFFF_8000);
    queue_load(0, 32'h0003_0000, 32'hFFFE_0000);
    queue_update(32'h0000_0000);
    queue_update(32'h0010_0000);
    drain();

    // random phases: new settings and a new idling mode each time
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 5)
        0:       write_reg(CFG_ALPHA, 32'h0001_0000);
        1:       write_reg(CFG_ALPHA, 32'h0000_0000);
        2:       write_reg(CFG_ALPHA, 32'h7FFF_FFFF);
        3:       write_reg(CFG_ALPHA, 32'h8000_0000);
        default: write_reg(CFG_ALPHA, $urandom_range(32'h0008_0000) - 32'h0004_0000);
      endcase
      case (ph % 6)
        0:       write_reg(CFG_SIZE, 64);
        1:       write_reg(CFG_SIZE, 1);
        2:       write_reg(CFG_SIZE, 127);
        3:       write_reg(CFG_SIZE, 0);
        default: write_reg(CFG_SIZE, $urandom_range(16, 2));
      endcase
      write_reg(CFG_ACCUM, DATA_W'((ph % 3) != 1));
      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 27; sink_stall_pct = 27; end
      endcase
      fill_stores();
      // mostly updates walking the triangle, with reloads landing mid-walk
      n_items = $urandom_range(100, 70);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(99) < 70) queue_update(rand_q16());
        else queue_load(IDX_W'($urandom_range(SIZE_CAP - 1)), rand_q16(), rand_q16());
      end
      drain();
    end

    src_idle_pct   = 0;
    sink_stall_pct = 0;
    drain();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
